// ===== hw/rtl/sync_checksum_frame_demux_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sync/checksum frame demultiplexer
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SYNC_CHECKSUM_FRAME_DEMUX_TOP_DEFINES_SVH
`define SYNC_CHECKSUM_FRAME_DEMUX_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and muted during reset.
`define SCFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and muted during reset.
`define SCFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/scfd_pkg.sv =====
// ----------------------------------------------------------------------------
// scfd_pkg
// Types and constants shared by the frame demultiplexer modules.
// ----------------------------------------------------------------------------
package scfd_pkg;

  localparam int unsigned HEADER_BYTES = 4;

  localparam logic [7:0] SYNC_BYTE_RST = 8'hF9;
  localparam logic [7:0] PROTO_VER_RST = 8'h00;

  typedef enum logic [1:0] {
    CFG_SYNC_BYTE = 2'd0,
    CFG_PROTO_VER = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_HEAD = 2'd1,
    MODE_BODY = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    KIND_TEXT      = 3'd0,
    KIND_HEAD_HELD = 3'd1,
    KIND_HEAD_OK   = 3'd2,
    KIND_HEAD_BAD  = 3'd3,
    KIND_BODY      = 3'd4
  } kind_t;

  // Position of the last header byte.
  localparam logic [7:0] HEAD_LAST_POS = 8'(HEADER_BYTES - 1);

  // Input register contents handed to the parser.
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } stage_t;

endpackage

// ===== hw/rtl/scfd_in_stage.sv =====
// ----------------------------------------------------------------------------
// scfd_in_stage
// Input register: captures one received byte per request.
// ----------------------------------------------------------------------------
module scfd_in_stage
  import scfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       take,
  output stage_t     stage
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       load;

  // The register may refill in the same cycle the parser empties it.
  assign in_ready  = !valid_r || take;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_rx_byte;
    end
  end

  assign stage.valid   = valid_r;
  assign stage.rx_byte = byte_r;

endmodule

// ===== hw/rtl/scfd_parser.sv =====
// ----------------------------------------------------------------------------
// scfd_parser
// Deframing state machine, configuration registers and result register.
// ----------------------------------------------------------------------------
module scfd_parser
  import scfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  stage_t     stage,
  output logic       take,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic [7:0] out_body_index,
  output logic       out_body_last,
  output logic [8:0] out_body_count
);

  logic [7:0] sync_byte_r;
  logic [7:0] proto_ver_r;

  mode_t      mode_r, mode_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       vm_r, vm_nxt;
  logic [7:0] len_r, len_nxt;
  logic       out_valid_r, out_valid_nxt;

  kind_t      kind_r, kind_nxt;
  logic [7:0] data_r;
  logic [7:0] index_r, index_nxt;
  logic       last_r, last_nxt;
  logic [8:0] count_r, count_nxt;

  logic [7:0] b;
  logic [7:0] h_pos, h_sum, h_sum_new;
  logic       h_vm, h_vm_new;
  logic [7:0] h_len_new;
  logic       load;

  assign b    = stage.rx_byte;
  assign load = stage.valid && (!out_valid_r || out_ready);
  assign take = load;

  // Configuration registers; out-of-range indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_byte_r <= SYNC_BYTE_RST;
      proto_ver_r <= PROTO_VER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_BYTE: sync_byte_r <= cfg_wdata;
        CFG_PROTO_VER: proto_ver_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A sync byte seen while idle enters the header with cleared accumulators.
  always_comb begin
    if (mode_r == MODE_HEAD) begin
      h_pos = pos_r;
      h_sum = sum_r;
      h_vm  = vm_r;
    end else begin
      h_pos = '0;
      h_sum = '0;
      h_vm  = 1'b0;
    end
    h_sum_new = h_sum + b;
    h_vm_new  = (h_pos == 8'd1) ? (b == proto_ver_r) : h_vm;
    h_len_new = (h_pos == 8'd2) ? b : len_r;
  end

  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    vm_nxt    = vm_r;
    len_nxt   = len_r;
    kind_nxt  = KIND_TEXT;
    index_nxt = '0;
    last_nxt  = 1'b0;
    count_nxt = '0;
    case (mode_r)
      MODE_IDLE, MODE_HEAD: begin
        if (mode_r == MODE_IDLE && b != sync_byte_r) begin
          kind_nxt = KIND_TEXT;
        end else begin
          sum_nxt = h_sum_new;
          vm_nxt  = h_vm_new;
          len_nxt = h_len_new;
          if (h_pos >= HEAD_LAST_POS) begin
            pos_nxt = '0;
            if (h_vm_new && h_sum_new == 8'd0) begin
              mode_nxt  = MODE_BODY;
              kind_nxt  = KIND_HEAD_OK;
              count_nxt = {1'b0, h_len_new} + 9'd1;
            end else begin
              mode_nxt = MODE_IDLE;
              kind_nxt = KIND_HEAD_BAD;
            end
          end else begin
            mode_nxt = MODE_HEAD;
            pos_nxt  = h_pos + 8'd1;
            kind_nxt = KIND_HEAD_HELD;
          end
        end
      end
      MODE_BODY: begin
        kind_nxt  = KIND_BODY;
        index_nxt = pos_r;
        last_nxt  = (pos_r >= len_r);
        count_nxt = {1'b0, len_r} + 9'd1;
        if (pos_r >= len_r) begin
          mode_nxt = MODE_IDLE;
          pos_nxt  = '0;
        end else begin
          pos_nxt = pos_r + 8'd1;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
        pos_nxt  = '0;
        kind_nxt = KIND_TEXT;
      end
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      pos_r       <= '0;
      sum_r       <= '0;
      vm_r        <= 1'b0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (load) begin
        mode_r <= mode_nxt;
        pos_r  <= pos_nxt;
        sum_r  <= sum_nxt;
        vm_r   <= vm_nxt;
        len_r  <= len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= kind_nxt;
      data_r  <= b;
      index_r <= index_nxt;
      last_r  <= last_nxt;
      count_r <= count_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_data_byte  = data_r;
  assign out_body_index = index_r;
  assign out_body_last  = last_r;
  assign out_body_count = count_r;

endmodule

// ===== hw/rtl/sync_checksum_frame_demux_top.sv =====
// ----------------------------------------------------------------------------
// sync_checksum_frame_demux_top
// Splits a byte line into plain text and sync/length/checksum framed bodies.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | input     | in_valid / in_ready  | in_rx_byte
//  out     | output    | out_valid / out_ready| kind, data, index, last, count
//  cfg     | input     | cfg_we               | cfg_index, cfg_wdata
//
//  One request per clock is taken unless the output stalls; one result per byte.
//  Each byte passes the input register, then the parser's result register.
//  The parser state advances only when a byte moves into the result register.
//  A stalled output holds its result; the input register still takes one more byte.
//  Synchronous active-low reset clears the frame state and restores the registers.
// ----------------------------------------------------------------------------
module sync_checksum_frame_demux_top
  import scfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic [7:0] out_body_index,
  output logic       out_body_last,
  output logic [8:0] out_body_count
);

  stage_t stage;
  logic   take;

  scfd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take       (take),
    .stage      (stage)
  );

  scfd_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .stage          (stage),
    .take           (take),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_data_byte  (out_data_byte),
    .out_body_index (out_body_index),
    .out_body_last  (out_body_last),
    .out_body_count (out_body_count)
  );

endmodule

// ===== hw/rtl/scfd_checker.sv =====
// ----------------------------------------------------------------------------
// scfd_checker
// Port-level checks on the frame demultiplexer results.
// ----------------------------------------------------------------------------
`include "sync_checksum_frame_demux_top_defines.svh"

module scfd_checker
  import scfd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_kind,
  input logic [7:0] out_data_byte,
  input logic [7:0] out_body_index,
  input logic       out_body_last,
  input logic [8:0] out_body_count
);

  logic        stalled;
  logic        body_res;
  logic        last_pos;
  logic        plain_res;
  logic        marked;
  logic        body_zero;
  logic [28:0] out_payload;

  assign stalled     = out_valid && !out_ready;
  assign body_res    = out_valid && (out_kind == KIND_BODY);
  assign last_pos    = ({1'b0, out_body_index} == (out_body_count - 9'd1));
  assign plain_res   = out_valid && (out_kind == KIND_TEXT || out_kind == KIND_HEAD_HELD ||
                                     out_kind == KIND_HEAD_BAD);
  assign marked      = out_valid && out_body_last;
  assign body_zero   = (out_body_index == 8'd0) && (out_body_count == 9'd0);
  assign out_payload = {out_kind, out_data_byte, out_body_index, out_body_last,
                        out_body_count};

  // A held result must not change until it is taken.
  `SCFD_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(out_payload), "held result changed")

  // The last mark sits exactly on the final body position.
  `SCFD_ASSERT_NOW(a_last_pos, body_res, out_body_last == last_pos, "body last mark misplaced")

  // Only body results carry a last mark.
  `SCFD_ASSERT_NOW(a_last_body, marked, out_kind == KIND_BODY, "last mark outside body")

  // Text, held-header and bad-header results report no body index or count.
  `SCFD_ASSERT_NOW(a_plain_zero, plain_res, body_zero, "stray body fields")

endmodule

bind sync_checksum_frame_demux_top scfd_checker u_scfd_checker (.*);

// ===== sim/tb_sync_checksum_frame_demux_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the sync/checksum frame demultiplexer
// Drives directed bytes, then text, good frames and broken headers through the
// valid/ready channels with random idling on both sides. Results are checked
// against fixed expectations or a built-in deframer of header and body state.
// ----------------------------------------------------------------------------
module tb_sync_checksum_frame_demux_top;
  import scfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int PHASES = 7;
  localparam int PHASE_BYTES = 190;
  localparam int MAX_IDLE = 18;

  // Indexes that the register port decodes to nothing.
  localparam logic [1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [1:0] CFG_SPARE_3 = 2'd3;

  typedef struct {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] body_index;
    logic       body_last;
    logic [8:0] body_count;
  } frame_result_t;

  typedef struct {
    bit            is_write;
    logic [1:0]    reg_idx;
    logic [7:0]    value;
    bit            typed;
    frame_result_t want;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_kind;
  logic [7:0] out_data_byte;
  logic [7:0] out_body_index;
  logic       out_body_last;
  logic [8:0] out_body_count;

  sync_checksum_frame_demux_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_data_byte (out_data_byte),
    .out_body_index(out_body_index),
    .out_body_last (out_body_last),
    .out_body_count(out_body_count)
  );

  always #5 clk = ~clk;

  // Deframer state and its copy of the registers.
  logic [7:0] sync_val = SYNC_BYTE_RST;
  logic [7:0] version_val = PROTO_VER_RST;
  mode_t      fr_mode = MODE_IDLE;
  logic [7:0] fr_pos = '0;
  logic [7:0] fr_sum = '0;
  logic       fr_ver_ok = 1'b0;
  logic [7:0] fr_len = '0;

  frame_result_t pending_results[$];
  frame_result_t seen_want;
  frame_result_t no_result;
  dir_row_t      dir_rows[$];

  int  err_count = 0;
  int  bytes_sent = 0;
  int  stall_cycles = 0;
  bit  held = 1'b0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  bit  long_hold = 1'b0;

  task automatic deframe_byte(input logic [7:0] b, output frame_result_t r);
    r.kind = KIND_TEXT;
    r.data_byte = b;
    r.body_index = '0;
    r.body_last = 1'b0;
    r.body_count = '0;
    if (!(fr_mode == MODE_IDLE && b != sync_val)) begin
      if (fr_mode == MODE_IDLE) begin
        fr_mode = MODE_HEAD;
        fr_pos = '0;
        fr_sum = '0;
        fr_ver_ok = 1'b0;
      end
      if (fr_mode == MODE_HEAD) begin
        // The checksum covers the bytes as received, sync byte included.
        fr_sum = fr_sum + b;
        if (fr_pos == 8'd1) begin
          fr_ver_ok = (b == version_val);
        end else if (fr_pos == 8'd2) begin
          fr_len = b;
        end
        if (fr_pos == HEADER_BYTES - 1) begin
          fr_pos = '0;
          if (fr_ver_ok && fr_sum == 8'd0) begin
            fr_mode = MODE_BODY;
            r.kind = KIND_HEAD_OK;
            r.body_count = {1'b0, fr_len} + 9'd1;
          end else begin
            fr_mode = MODE_IDLE;
            r.kind = KIND_HEAD_BAD;
          end
        end else begin
          fr_pos = fr_pos + 8'd1;
          r.kind = KIND_HEAD_HELD;
        end
      end else if (fr_mode == MODE_BODY) begin
        r.kind = KIND_BODY;
        r.body_index = fr_pos;
        r.body_last = (fr_pos >= fr_len);
        r.body_count = {1'b0, fr_len} + 9'd1;
        if (r.body_last) begin
          fr_mode = MODE_IDLE;
          fr_pos = '0;
        end else begin
          fr_pos = fr_pos + 8'd1;
        end
      end else begin
        fr_mode = MODE_IDLE;
        fr_pos = '0;
      end
    end
  endtask

  // After an accepted request, in_valid stays high so that a back-to-back
  // request needs no second assignment in the same step.
  task automatic send_byte(input logic [7:0] b, input bit typed, input frame_result_t want);
    int gap;
    frame_result_t r;
    gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      if (held) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    held = 1'b1;
    bytes_sent++;
    deframe_byte(b, r);
    if (typed) r = want;
    pending_results.push_back(r);
  endtask

  task automatic wait_drain();
    if (held) in_valid <= 1'b0;
    held = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
    wait_drain();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SYNC_BYTE) sync_val = v;
    else if (idx == CFG_PROTO_VER) version_val = v;
  endtask

  task automatic send_text(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom);
      // Mostly keep plain text away from the sync value.
      if (b == sync_val && $urandom_range(0, 7) != 0) b = b ^ 8'h01;
      send_byte(b, 1'b0, no_result);
    end
  endtask

  // flaw: 0 good frame, 1 wrong version, 2 wrong checksum, 3 both.
  task automatic send_frame(input int flaw);
    logic [7:0] ver;
    logic [7:0] len;
    logic [7:0] chk;
    int pick;
    ver = version_val;
    pick = $urandom_range(0, 99);
    if (pick < 3) len = 8'hFF;
    else if (pick < 15) len = 8'($urandom_range(16, 254));
    else len = 8'($urandom_range(0, 15));
    if (flaw == 1 || flaw == 3) ver = ver ^ 8'($urandom_range(1, 255));
    chk = 8'd0 - sync_val - ver - len;
    if (flaw == 2 || flaw == 3) chk = chk + 8'($urandom_range(1, 255));
    send_byte(sync_val, 1'b0, no_result);
    send_byte(ver, 1'b0, no_result);
    send_byte(len, 1'b0, no_result);
    send_byte(chk, 1'b0, no_result);
    if (flaw == 0) begin
      for (int i = 0; i <= len; i++) send_byte(8'($urandom), 1'b0, no_result);
    end
  endtask

  function automatic logic [7:0] pick_reg_value();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      2: return SYNC_BYTE_RST;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void row_byte(input logic [7:0] b);
    dir_row_t row;
    row.is_write = 1'b0;
    row.reg_idx = '0;
    row.value = b;
    row.typed = 1'b0;
    row.want = no_result;
    dir_rows.push_back(row);
  endfunction

  function automatic void row_typed(input logic [7:0] b, input kind_t k, input logic [8:0] cnt);
    dir_row_t row;
    row.is_write = 1'b0;
    row.reg_idx = '0;
    row.value = b;
    row.typed = 1'b1;
    row.want.kind = k;
    row.want.data_byte = b;
    row.want.body_index = '0;
    row.want.body_last = 1'b0;
    row.want.body_count = cnt;
    dir_rows.push_back(row);
  endfunction

  function automatic void row_write(input logic [1:0] idx, input logic [7:0] v);
    dir_row_t row;
    row.is_write = 1'b1;
    row.reg_idx = idx;
    row.value = v;
    row.typed = 1'b0;
    row.want = no_result;
    dir_rows.push_back(row);
  endfunction

  initial begin : main
    int sel;
    int phase_end;
    bit hold_done;
    bit pause_done;
    hold_done = 1'b0;
    pause_done = 1'b0;
    no_result.kind = KIND_TEXT;
    no_result.data_byte = '0;
    no_result.body_index = '0;
    no_result.body_last = 1'b0;
    no_result.body_count = '0;

    // Reset values: text passes, a good header with length field one (two body bytes).
    row_typed(8'h00, KIND_TEXT, 9'd0);
    row_typed(8'hFF, KIND_TEXT, 9'd0);
    row_typed(8'hF9, KIND_HEAD_HELD, 9'd0);
    row_byte(8'h00);
    row_byte(8'h01);
    row_typed(8'h06, KIND_HEAD_OK, 9'd2);
    row_byte(8'h00);
    row_byte(8'hFF);
    // Wrong version with a correct checksum, then a bad checksum.
    row_byte(8'hF9);
    row_byte(8'h01);
    row_byte(8'h00);
    row_typed(8'h06, KIND_HEAD_BAD, 9'd0);
    row_byte(8'hF9);
    row_byte(8'h00);
    row_byte(8'h00);
    row_typed(8'h00, KIND_HEAD_BAD, 9'd0);
    // Extreme register values; writes to the spare indexes must be ignored.
    row_write(CFG_SYNC_BYTE, 8'h00);
    row_write(CFG_PROTO_VER, 8'hFF);
    row_write(CFG_SPARE_2, 8'hAA);
    row_write(CFG_SPARE_3, 8'h55);
    row_byte(8'h00);
    row_byte(8'hFF);
    row_byte(8'h00);
    row_typed(8'h01, KIND_HEAD_OK, 9'd1);
    row_byte(8'h5A);
    // Registers change while a header is open.
    row_write(CFG_SYNC_BYTE, 8'hFF);
    row_write(CFG_PROTO_VER, 8'h00);
    row_byte(8'hFF);
    row_write(CFG_PROTO_VER, 8'h12);
    row_write(CFG_SYNC_BYTE, 8'h12);
    row_byte(8'h12);
    row_byte(8'h00);
    row_byte(8'hEF);
    row_byte(8'h12);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_write) write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
      else send_byte(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      tx_idle_on = (ph != 0) && ($urandom_range(0, 3) != 0);
      rx_idle_on = (ph != 0) && ($urandom_range(0, 3) != 0);
      write_reg(CFG_SYNC_BYTE, pick_reg_value());
      write_reg(CFG_PROTO_VER, pick_reg_value());
      if ($urandom_range(0, 2) == 0) write_reg(ph[0] ? CFG_SPARE_2 : CFG_SPARE_3, 8'($urandom));
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        // The receiver holds off once so the block fills and backs up.
        if (ph == 2 && !hold_done && bytes_sent > phase_end - PHASE_BYTES / 2) begin
          long_hold = 1'b1;
          hold_done = 1'b1;
        end
        if (ph == 4 && !pause_done && bytes_sent > phase_end - PHASE_BYTES / 2) begin
          wait_drain();
          pause_done = 1'b1;
        end
        sel = $urandom_range(0, 99);
        if (sel < 60) send_frame(0);
        else if (sel < 75) send_frame($urandom_range(1, 3));
        else send_text($urandom_range(1, 6));
      end
    end

    wait_drain();
    repeat (10) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : receiver
    int stall;
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
      stall = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic check_field(input string what, input logic [8:0] want, input logic [8:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t ns: unexpected result, expected none, actual kind %0h data %0h",
                 $time, out_kind, out_data_byte);
      end else begin
        seen_want = pending_results.pop_front();
        check_field("kind", 9'(seen_want.kind), 9'(out_kind));
        check_field("data_byte", 9'(seen_want.data_byte), 9'(out_data_byte));
        check_field("body_index", 9'(seen_want.body_index), 9'(out_body_index));
        check_field("body_last", 9'(seen_want.body_last), 9'(out_body_last));
        check_field("body_count", seen_want.body_count, out_body_count);
      end
    end
  end

  // Ends the run when no request moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog expired with %0d results pending",
               $time, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
